FILE: hdl/ntn_pkg.sv
// Shared types, constants and key helper for the name-to-node table.
package ntn_pkg;

  localparam int NODES_DEF       = 16;
  localparam int NAME_BYTES_DEF  = 8;
  localparam int SERVER_SLOT_DEF = 0;
  localparam int KEY_W           = 64;

  // "/io0", first character in the low byte
  localparam logic [KEY_W-1:0] SERVER_KEY = 64'h0000_0000_306F_692F;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_LINK   = 2'd1;
  localparam logic [1:0] MODE_UNLINK = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] name_key;
    logic [7:0]       node;
  } in_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] found_node;
    logic [4:0] count;
  } out_t;

  // Cut the key at its first zero byte and clear bytes at or above nbytes.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k,
                                                input int unsigned nbytes);
    logic [KEY_W-1:0] r;
    logic             stop;
    r    = '0;
    stop = 1'b0;
    for (int unsigned i = 0; i < 8; i++) begin
      if (i >= nbytes || k[8*i +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*i +: 8] = k[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/ntn_mem.sv
// Key store: one synchronous-read memory with per-entry valid bits.
module ntn_mem #(
  parameter int NODES       = ntn_pkg::NODES_DEF,
  parameter int NAME_BYTES  = ntn_pkg::NAME_BYTES_DEF,
  parameter int SERVER_SLOT = ntn_pkg::SERVER_SLOT_DEF,
  localparam int AW         = $clog2(NODES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [ntn_pkg::KEY_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ntn_pkg::KEY_W-1:0] wr_data
);

  localparam logic SRV_EN = (SERVER_SLOT < NODES);
  localparam logic [ntn_pkg::KEY_W-1:0] SRV_KEY =
    ntn_pkg::norm_key(ntn_pkg::SERVER_KEY, NAME_BYTES);

  logic [ntn_pkg::KEY_W-1:0] mem_r [NODES];
  logic [NODES-1:0]          vld_r;
  logic [ntn_pkg::KEY_W-1:0] dat_r;
  logic                      dat_vld_r;
  logic [AW-1:0]             dat_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      dat_r      <= mem_r[rd_addr];
      dat_vld_r  <= vld_r[rd_addr];
      dat_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // An entry never written since reset reads as zero, or as the server key in the server slot.
  always_comb begin
    if (dat_vld_r) begin
      rd_data = dat_r;
    end else if (SRV_EN && {1'b0, dat_addr_r} == (AW+1)'(SERVER_SLOT)) begin
      rd_data = SRV_KEY;
    end else begin
      rd_data = '0;
    end
  end

endmodule

FILE: hdl/ntn_ctrl.sv
// Request sequencer: scan all slots through the key store, then write back on a successful link or unlink.
module ntn_ctrl #(
  parameter int NODES       = ntn_pkg::NODES_DEF,
  parameter int NAME_BYTES  = ntn_pkg::NAME_BYTES_DEF,
  localparam int AW         = $clog2(NODES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  ntn_pkg::in_t              cmd_data,
  output logic                      idle,
  output logic                      res_valid,
  input  logic                      res_ready,
  output ntn_pkg::out_t             res_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic [ntn_pkg::KEY_W-1:0] rd_data,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [ntn_pkg::KEY_W-1:0] wr_data
);

  localparam int CW = $clog2(NODES + 1);
  localparam logic [AW-1:0] LAST = AW'(NODES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } st_t;

  st_t                       st_r, st_nxt;
  logic [1:0]                mode_r, mode_nxt;
  logic [ntn_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                      key_nz_r, key_nz_nxt;
  logic [7:0]                node_r, node_nxt;
  logic [AW-1:0]             iss_r, iss_nxt;
  logic                      iss_done_r, iss_done_nxt;
  logic                      pend_r, pend_nxt;
  logic [AW-1:0]             pend_idx_r, pend_idx_nxt;
  logic                      hit_r, hit_nxt;
  logic [AW-1:0]             hit_idx_r, hit_idx_nxt;
  logic                      occ_r, occ_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;

  logic                      node_in;
  logic                      ok;
  logic                      do_wr;
  logic [CW-1:0]             cnt_new;
  logic [CW+4:0]             cnt_ext;
  logic [AW+3:0]             idx_ext;

  assign node_in = {1'b0, node_r} < 9'(NODES);

  // Decide the outcome from the scan flags.
  always_comb begin
    ok      = 1'b0;
    do_wr   = 1'b0;
    cnt_new = cnt_r;
    wr_addr = hit_idx_r;
    wr_data = '0;
    unique case (mode_r)
      ntn_pkg::MODE_LOOKUP: begin
        ok = hit_r;
      end
      ntn_pkg::MODE_LINK: begin
        wr_addr = node_r[AW-1:0];
        wr_data = key_r;
        if (key_nz_r && cnt_r < CW'(NODES) && !hit_r && node_in && !occ_r) begin
          ok      = 1'b1;
          do_wr   = 1'b1;
          cnt_new = cnt_r + 1'b1;
        end
      end
      ntn_pkg::MODE_UNLINK: begin
        if (cnt_r != '0 && hit_r) begin
          ok      = 1'b1;
          do_wr   = 1'b1;
          cnt_new = cnt_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext = {5'b0, cnt_new};
  assign idx_ext = {4'b0, hit_idx_r};

  assign idle                = (st_r == ST_IDLE);
  assign res_valid           = (st_r == ST_FIN);
  assign res_data.ok         = ok;
  assign res_data.found_node = (mode_r == ntn_pkg::MODE_LOOKUP && hit_r) ? idx_ext[3:0] : 4'd0;
  assign res_data.count      = cnt_ext[4:0];
  assign wr_en               = res_valid && res_ready && do_wr;
  assign rd_en               = (st_r == ST_SCAN) && !iss_done_r;
  assign rd_addr             = iss_r;

  always_comb begin
    st_nxt       = st_r;
    mode_nxt     = mode_r;
    key_nxt      = key_r;
    key_nz_nxt   = key_nz_r;
    node_nxt     = node_r;
    iss_nxt      = iss_r;
    iss_done_nxt = iss_done_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = iss_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    occ_nxt      = occ_r;
    cnt_nxt      = cnt_r;
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          mode_nxt     = cmd_data.mode;
          key_nxt      = ntn_pkg::norm_key(cmd_data.name_key, NAME_BYTES);
          key_nz_nxt   = (key_nxt != '0);
          node_nxt     = cmd_data.node;
          iss_nxt      = '0;
          iss_done_nxt = 1'b0;
          hit_nxt      = 1'b0;
          hit_idx_nxt  = '0;
          occ_nxt      = 1'b0;
          st_nxt       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one read a cycle
        if (rd_en) begin
          pend_nxt = 1'b1;
          if (iss_r == LAST) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_nxt = iss_r + 1'b1;
          end
        end
        // compare the word read last cycle
        if (pend_r) begin
          if (key_nz_r && !hit_r && rd_data == key_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = pend_idx_r;
          end
          if (pend_idx_r == node_r[AW-1:0]) begin
            occ_nxt = (rd_data != '0);
          end
          if (pend_idx_r == LAST) begin
            st_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (res_ready) begin
          cnt_nxt = cnt_new;
          st_nxt  = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    key_nz_r   <= key_nz_nxt;
    node_r     <= node_nxt;
    iss_r      <= iss_nxt;
    iss_done_r <= iss_done_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    occ_r      <= occ_nxt;
  end

endmodule

FILE: hdl/name_to_node_table.sv
// Top level of the name-to-node table: sequencer, key store and output register.
//
// The in_ channel carries one request word (mode, name_key, node): lookup, link
// or unlink of a name key. Every request returns exactly one result word on the
// out_ channel (ok, found_node, count). There is no configuration port.
//
// Sequence: after a word is taken, every slot is read from the key store, one
// read per cycle, with each compare in the cycle after its read. A final state
// then decides, writes back and loads the output register, raising out_valid.
// The next word is taken only when that state has handed its result on, so a
// new request is never taken before the last one is through. Reads and the
// write-back never overlap, so no forwarding.
//
// Reset: rst_n clears the count and all entry valid bits; slots then read
// empty except the server slot, which reads "/io0". No clearing pass.
//
// Stall: a result held in the output register does not block the next request;
// the following result waits in the sequencer, holding off the next word, until
// the output register frees.
module name_to_node_table #(
  parameter int NODES       = ntn_pkg::NODES_DEF,
  parameter int NAME_BYTES  = ntn_pkg::NAME_BYTES_DEF,
  parameter int SERVER_SLOT = ntn_pkg::SERVER_SLOT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ntn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ntn_pkg::out_t out_data
);

  localparam int AW = $clog2(NODES);

  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [ntn_pkg::KEY_W-1:0] rd_data;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [ntn_pkg::KEY_W-1:0] wr_data;

  logic                      res_valid;
  logic                      res_ready;
  ntn_pkg::out_t             res_data;

  logic                      out_valid_r, out_valid_nxt;
  ntn_pkg::out_t             out_data_r;

  // Sequencer: takes a word only when idle.
  ntn_ctrl #(
    .NODES      (NODES),
    .NAME_BYTES (NAME_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_valid),
    .cmd_data  (in_data),
    .idle      (in_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Key store, one port read per cycle, write-back after the scan.
  ntn_mem #(
    .NODES       (NODES),
    .NAME_BYTES  (NAME_BYTES),
    .SERVER_SLOT (SERVER_SLOT)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Output register: free when empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load a fresh result word; hold it otherwise.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/ntn_chk.sv
// Port-level checker for the name-to-node table, bound to the top level.
module ntn_chk #(
  parameter int NODES = ntn_pkg::NODES_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ntn_pkg::out_t out_data
);

  // Stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // One request at a time: busy right after taking a word.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // Only a successful lookup reports a slot.
  a_fnode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.found_node == 4'd0)
    else $error("slot reported on failure");

  // Count never exceeds the slot count; checked only up to 16 slots.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (NODES > 16 || out_data.count <= 5'(NODES)))
    else $error("count above slot count");

  // Reset drops any pending result.
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind name_to_node_table ntn_chk #(
  .NODES (NODES)
) u_ntn_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
